// File: rtl/tle_pkg.sv
// Terminal line editor package: shared types, codes and sizes.
// Used by the stream interface, the character cell and the top level.
package tle_pkg;

   // Largest line the store can be built for, and the width that counts to it
   localparam int MAX_CAPACITY     = 64;
   localparam int POS_W            = $clog2(MAX_CAPACITY + 1);
   localparam int DEFAULT_CAPACITY = 64;
   localparam int CHAR_W           = 7;

   // Received byte codes
   localparam logic [7:0] BYTE_NEWLINE   = 8'd10;
   localparam logic [7:0] BYTE_ESC       = 8'd27;
   localparam logic [7:0] BYTE_PRINT_LO  = 8'd32;
   localparam logic [7:0] BYTE_PRINT_HI  = 8'd126;
   localparam logic [7:0] BYTE_DELETE    = 8'd127;
   localparam logic [7:0] BYTE_BRACKET   = 8'h5B; // '['
   localparam logic [7:0] BYTE_LEFT      = 8'h44; // 'D'
   localparam logic [7:0] BYTE_RIGHT     = 8'h43; // 'C'
   localparam logic [7:0] BYTE_FOUR      = 8'h34; // '4'
   localparam logic [7:0] BYTE_ONE       = 8'h31; // '1'
   localparam logic [7:0] BYTE_TILDE     = 8'h7E; // '~'

   typedef enum logic [2:0] {
      ESC_IDLE,
      ESC_GOT_ESC,
      ESC_GOT_BRACKET,
      ESC_GOT_FOUR,
      ESC_GOT_ONE
   } esc_type;

   typedef enum logic {
      ST_EDIT,
      ST_EMIT
   } state_type;

   // Operation broadcast to every cell of the row
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_SHIFT_OUT
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [POS_W-1:0]  pos;
      logic [CHAR_W-1:0] ch;
   } cell_cmd_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              is_last;
      logic              line_empty;
      logic              overflowed;
   } rsp_payload_type;

endpackage

// File: rtl/tle_stream_if.sv
// Valid/ready stream channel carrying one payload per beat.
// Depends on tle_pkg for the default payload type.
interface tle_stream_if #(
   parameter type payload_type = tle_pkg::req_payload_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/tle_cell.sv
// One character slot of the line row; takes from a neighbor or the command on a broadcast op.
// Depends on tle_pkg for the command type and widths.
module tle_cell #(
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  tle_pkg::cell_cmd_type         cmd,
   input  logic [tle_pkg::CHAR_W-1:0]    left_char,
   input  logic [tle_pkg::CHAR_W-1:0]    right_char,
   output logic [tle_pkg::CHAR_W-1:0]    char_out
);

   localparam logic [tle_pkg::POS_W-1:0] MY_POS = tle_pkg::POS_W'(INDEX);

   logic [tle_pkg::CHAR_W-1:0] char_ff;
   logic [tle_pkg::CHAR_W-1:0] char_in;

   // Pick the next character from the op and where this cell sits
   always_comb begin
      char_in = char_ff;
      unique case (cmd.op)
         tle_pkg::CELL_INSERT: begin
            if (MY_POS > cmd.pos) begin
               char_in = left_char;
            end else if (MY_POS == cmd.pos) begin
               char_in = cmd.ch;
            end
         end
         tle_pkg::CELL_DELETE: begin
            if (MY_POS >= cmd.pos) begin
               char_in = right_char;
            end
         end
         tle_pkg::CELL_SHIFT_OUT: char_in = right_char;
         tle_pkg::CELL_HOLD:      char_in = char_ff;
         default:                 char_in = char_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   assign char_out = char_ff;

endmodule

// File: rtl/terminal_line_editor.sv
// Terminal line editor top level: escape decoder, cursor control and cell row.
// Depends on tle_pkg, tle_stream_if and tle_cell.
//
// The editor takes one received byte per cycle while editing: inserts and
// deletes move the whole row of character cells at once, each cell taking
// from its neighbor. A newline emits the line one character per beat by
// shifting the row toward cell 0. A line that is not empty holds off the
// input until its last character is in the output register.
// A result beat waiting in the output register holds off the next byte until
// it is taken. An insert into a full line is dropped and marked on every beat
// of that line.
module terminal_line_editor #(
   parameter int LINE_CAPACITY = tle_pkg::DEFAULT_CAPACITY
) (
   input  logic            clock,
   input  logic            reset,
   tle_stream_if.sink      req,
   tle_stream_if.source    rsp
);

   localparam int                         POS_W   = tle_pkg::POS_W;
   localparam int                         CHAR_W  = tle_pkg::CHAR_W;
   localparam logic [POS_W-1:0]           CAP_POS = POS_W'(LINE_CAPACITY);
   localparam logic [POS_W-1:0]           ONE_POS = POS_W'(1);

   tle_pkg::state_type   state_ff,   state_in;
   tle_pkg::esc_type     esc_ff,     esc_in;
   logic [POS_W-1:0]     len_ff,     len_in;
   logic [POS_W-1:0]     cur_ff,     cur_in;
   logic [POS_W-1:0]     rem_ff,     rem_in;
   logic                 ovf_ff,     ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tle_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   tle_pkg::cell_cmd_type cmd;
   logic [CHAR_W-1:0]     cell_char [LINE_CAPACITY];

   logic       slot_free;
   logic       take;
   logic [7:0] b;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == tle_pkg::ST_EDIT) && slot_free;
   assign take      = req.valid && req.ready;
   assign b         = req.payload.rx_byte;

   // Decode the byte, steer the cell row and feed the output register
   always_comb begin
      state_in     = state_ff;
      esc_in       = esc_ff;
      len_in       = len_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      cmd.op       = tle_pkg::CELL_HOLD;
      cmd.pos      = cur_ff;
      cmd.ch       = b[CHAR_W-1:0];

      unique case (state_ff)
         tle_pkg::ST_EDIT: begin
            if (take) begin
               unique case (esc_ff)
                  tle_pkg::ESC_GOT_ESC: begin
                     esc_in = (b == tle_pkg::BYTE_BRACKET) ? tle_pkg::ESC_GOT_BRACKET
                                                           : tle_pkg::ESC_IDLE;
                  end
                  tle_pkg::ESC_GOT_BRACKET: begin
                     esc_in = tle_pkg::ESC_IDLE;
                     priority if (b == tle_pkg::BYTE_LEFT) begin
                        if (cur_ff != '0) cur_in = cur_ff - ONE_POS;
                     end else if (b == tle_pkg::BYTE_RIGHT) begin
                        if (cur_ff < len_ff) cur_in = cur_ff + ONE_POS;
                     end else if (b == tle_pkg::BYTE_FOUR) begin
                        esc_in = tle_pkg::ESC_GOT_FOUR;
                     end else if (b == tle_pkg::BYTE_ONE) begin
                        esc_in = tle_pkg::ESC_GOT_ONE;
                     end else begin
                        esc_in = tle_pkg::ESC_IDLE;
                     end
                  end
                  tle_pkg::ESC_GOT_FOUR: begin
                     esc_in = tle_pkg::ESC_IDLE;
                     if (b == tle_pkg::BYTE_TILDE) cur_in = len_ff;
                  end
                  tle_pkg::ESC_GOT_ONE: begin
                     esc_in = tle_pkg::ESC_IDLE;
                     if (b == tle_pkg::BYTE_TILDE) cur_in = '0;
                  end
                  default: begin
                     esc_in = tle_pkg::ESC_IDLE;
                     priority if (b == tle_pkg::BYTE_NEWLINE) begin
                        if (len_ff == '0) begin
                           // Empty line: one beat, then clear
                           rsp_valid_in            = 1'b1;
                           rsp_data_in.out_char    = '0;
                           rsp_data_in.is_last     = 1'b1;
                           rsp_data_in.line_empty  = 1'b1;
                           rsp_data_in.overflowed  = ovf_ff;
                           ovf_in                  = 1'b0;
                           cur_in                  = '0;
                        end else begin
                           state_in = tle_pkg::ST_EMIT;
                           rem_in   = len_ff;
                        end
                     end else if (b >= tle_pkg::BYTE_PRINT_LO &&
                                  b <= tle_pkg::BYTE_PRINT_HI) begin
                        if (len_ff == CAP_POS) begin
                           ovf_in = 1'b1;
                        end else begin
                           cmd.op = tle_pkg::CELL_INSERT;
                           len_in = len_ff + ONE_POS;
                           cur_in = cur_ff + ONE_POS;
                        end
                     end else if (b == tle_pkg::BYTE_DELETE) begin
                        if (cur_ff != '0) begin
                           cmd.op  = tle_pkg::CELL_DELETE;
                           cmd.pos = cur_ff - ONE_POS;
                           len_in  = len_ff - ONE_POS;
                           cur_in  = cur_ff - ONE_POS;
                        end
                     end else if (b == tle_pkg::BYTE_ESC) begin
                        esc_in = tle_pkg::ESC_GOT_ESC;
                     end else begin
                        esc_in = tle_pkg::ESC_IDLE;
                     end
                  end
               endcase
            end
         end
         tle_pkg::ST_EMIT: begin
            // Drain cell 0 into the output register, shift the row left
            if (slot_free) begin
               cmd.op                  = tle_pkg::CELL_SHIFT_OUT;
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_char    = cell_char[0];
               rsp_data_in.is_last     = (rem_ff == ONE_POS);
               rsp_data_in.line_empty  = 1'b0;
               rsp_data_in.overflowed  = ovf_ff;
               rem_in                  = rem_ff - ONE_POS;
               if (rem_ff == ONE_POS) begin
                  state_in = tle_pkg::ST_EDIT;
                  len_in   = '0;
                  cur_in   = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: state_in = tle_pkg::ST_EDIT;
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tle_pkg::ST_EDIT;
         esc_ff       <= tle_pkg::ESC_IDLE;
         len_ff       <= '0;
         cur_ff       <= '0;
         rem_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         esc_ff       <= esc_in;
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         rem_ff       <= rem_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result beat
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // Row of character cells, each linked to both neighbors
   for (genvar i = 0; i < LINE_CAPACITY; i++) begin : g_cell
      logic [CHAR_W-1:0] left_char;
      logic [CHAR_W-1:0] right_char;

      if (i == 0) begin : g_first
         assign left_char = '0;
      end else begin : g_mid_l
         assign left_char = cell_char[i-1];
      end

      if (i == LINE_CAPACITY - 1) begin : g_last
         assign right_char = '0;
      end else begin : g_mid_r
         assign right_char = cell_char[i+1];
      end

      tle_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_char  (left_char),
         .right_char (right_char),
         .char_out   (cell_char[i])
      );
   end

endmodule

// File: tb/tb.sv
// Self-checking testbench for terminal_line_editor: edits, cursor keys, escapes, full line.
// Depends on tle_pkg and tle_stream_if from the RTL. It predicts every emitted line character
// and checks each result beat against it.
module tb;

   localparam int CAPACITY     = tle_pkg::DEFAULT_CAPACITY;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = CAPACITY + 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tle_stream_if #(.payload_type(tle_pkg::req_payload_type)) req_if ();
   tle_stream_if #(.payload_type(tle_pkg::rsp_payload_type)) rsp_if ();

   terminal_line_editor #(.LINE_CAPACITY(CAPACITY)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // Editor state as predicted from the accepted bytes
   logic [tle_pkg::CHAR_W-1:0] line_chars[$];
   int                         cursor        = 0;
   tle_pkg::esc_type           esc_seq       = tle_pkg::ESC_IDLE;
   bit                         line_overflow = 1'b0;
   tle_pkg::rsp_payload_type   expected_chars[$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int error_count   = 0;
   int bytes_sent    = 0;
   int chars_checked = 0;
   int lines_checked = 0;
   int cycle_count   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the editor state by one accepted byte; queue the line on newline
   function automatic void apply_rx_byte(input logic [7:0] rx);
      tle_pkg::rsp_payload_type beat;
      case (esc_seq)
         tle_pkg::ESC_GOT_ESC: begin
            if (rx == tle_pkg::BYTE_BRACKET) esc_seq = tle_pkg::ESC_GOT_BRACKET;
            else esc_seq = tle_pkg::ESC_IDLE;
            return;
         end
         tle_pkg::ESC_GOT_BRACKET: begin
            esc_seq = tle_pkg::ESC_IDLE;
            if (rx == tle_pkg::BYTE_LEFT) begin
               if (cursor > 0) cursor--;
            end else if (rx == tle_pkg::BYTE_RIGHT) begin
               if (cursor < line_chars.size()) cursor++;
            end else if (rx == tle_pkg::BYTE_FOUR) begin
               esc_seq = tle_pkg::ESC_GOT_FOUR;
            end else if (rx == tle_pkg::BYTE_ONE) begin
               esc_seq = tle_pkg::ESC_GOT_ONE;
            end
            return;
         end
         tle_pkg::ESC_GOT_FOUR: begin
            esc_seq = tle_pkg::ESC_IDLE;
            if (rx == tle_pkg::BYTE_TILDE) cursor = line_chars.size();
            return;
         end
         tle_pkg::ESC_GOT_ONE: begin
            esc_seq = tle_pkg::ESC_IDLE;
            if (rx == tle_pkg::BYTE_TILDE) cursor = 0;
            return;
         end
         default: esc_seq = tle_pkg::ESC_IDLE;
      endcase

      if (rx == tle_pkg::BYTE_NEWLINE) begin
         if (line_chars.size() == 0) begin
            beat.out_char   = '0;
            beat.is_last    = 1'b1;
            beat.line_empty = 1'b1;
            beat.overflowed = line_overflow;
            expected_chars.push_back(beat);
         end else begin
            for (int k = 0; k < line_chars.size(); k++) begin
               beat.out_char   = line_chars[k];
               beat.is_last    = (k == line_chars.size() - 1);
               beat.line_empty = 1'b0;
               beat.overflowed = line_overflow;
               expected_chars.push_back(beat);
            end
         end
         line_chars.delete();
         cursor        = 0;
         line_overflow = 1'b0;
      end else if (rx >= tle_pkg::BYTE_PRINT_LO && rx <= tle_pkg::BYTE_PRINT_HI) begin
         // Drop the insert when the store is full
         if (line_chars.size() >= CAPACITY) begin
            line_overflow = 1'b1;
         end else begin
            line_chars.insert(cursor, rx[tle_pkg::CHAR_W-1:0]);
            cursor++;
         end
      end else if (rx == tle_pkg::BYTE_DELETE) begin
         if (cursor > 0) begin
            line_chars.delete(cursor - 1);
            cursor--;
         end
      end else if (rx == tle_pkg::BYTE_ESC) begin
         esc_seq = tle_pkg::ESC_GOT_ESC;
      end
   endfunction

   // Send one byte, idling at random first; hold valid until the beat is taken
   task automatic send_byte(input logic [7:0] rx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.payload.rx_byte <= rx;
      do @(posedge clock); while (!req_if.ready);
      apply_rx_byte(rx);
      bytes_sent++;
   endtask

   task automatic send_csi(input logic [7:0] final_byte);
      send_byte(tle_pkg::BYTE_ESC);
      send_byte(tle_pkg::BYTE_BRACKET);
      send_byte(final_byte);
   endtask

   // Home is ESC [ 1 ~, end is ESC [ 4 ~
   task automatic send_csi_tilde(input logic [7:0] digit);
      send_csi(digit);
      send_byte(tle_pkg::BYTE_TILDE);
   endtask

   function automatic logic [7:0] random_printable();
      return 8'($urandom_range(tle_pkg::BYTE_PRINT_LO, tle_pkg::BYTE_PRINT_HI));
   endfunction

   // Check each result beat against the oldest expected character; stall at random
   always @(posedge clock) begin
      tle_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_chars.size() == 0) begin
               error_count++;
               $display("%0t: unexpected beat, actual char %0d last %0b empty %0b ovf %0b",
                        $time, rsp_if.payload.out_char, rsp_if.payload.is_last,
                        rsp_if.payload.line_empty, rsp_if.payload.overflowed);
            end else begin
               want = expected_chars.pop_front();
               chars_checked++;
               if (want.is_last) lines_checked++;
               if (rsp_if.payload.out_char !== want.out_char) begin
                  error_count++;
                  $display("%0t: out_char expected %0d actual %0d",
                           $time, want.out_char, rsp_if.payload.out_char);
               end
               if (rsp_if.payload.is_last !== want.is_last) begin
                  error_count++;
                  $display("%0t: is_last expected %0b actual %0b",
                           $time, want.is_last, rsp_if.payload.is_last);
               end
               if (rsp_if.payload.line_empty !== want.line_empty) begin
                  error_count++;
                  $display("%0t: line_empty expected %0b actual %0b",
                           $time, want.line_empty, rsp_if.payload.line_empty);
               end
               if (rsp_if.payload.overflowed !== want.overflowed) begin
                  error_count++;
                  $display("%0t: overflowed expected %0b actual %0b",
                           $time, want.overflowed, rsp_if.payload.overflowed);
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d result beats outstanding", $time, expected_chars.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Empty line, inserts at both ends, delete and cursor keys at their limits
   task automatic test_edit_keys();
      send_byte(tle_pkg::BYTE_NEWLINE);
      send_byte(tle_pkg::BYTE_DELETE);
      send_csi(tle_pkg::BYTE_LEFT);
      send_byte(tle_pkg::BYTE_PRINT_LO);
      send_byte(tle_pkg::BYTE_PRINT_HI);
      send_csi(tle_pkg::BYTE_RIGHT);
      send_csi_tilde(tle_pkg::BYTE_ONE);
      send_byte(8'h61);
      send_csi(tle_pkg::BYTE_RIGHT);
      send_csi_tilde(tle_pkg::BYTE_FOUR);
      send_byte(tle_pkg::BYTE_DELETE);
      send_byte(tle_pkg::BYTE_NEWLINE);
   endtask

   // Broken sequences are consumed, stray control and high bytes are ignored
   task automatic test_escape_breaks();
      send_byte(8'h41);
      send_byte(tle_pkg::BYTE_ESC);
      send_byte(tle_pkg::BYTE_NEWLINE);
      send_csi(8'h5A);
      send_csi(tle_pkg::BYTE_FOUR);
      send_byte(8'h78);
      send_csi(tle_pkg::BYTE_ONE);
      send_byte(tle_pkg::BYTE_NEWLINE);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(tle_pkg::BYTE_NEWLINE);
   endtask

   // A line filled to capacity, with inserts dropped at the start and end
   task automatic test_full_line();
      repeat (CAPACITY) send_byte(random_printable());
      send_csi_tilde(tle_pkg::BYTE_ONE);
      send_byte(random_printable());
      send_csi(tle_pkg::BYTE_RIGHT);
      send_byte(tle_pkg::BYTE_DELETE);
      send_byte(random_printable());
      send_csi_tilde(tle_pkg::BYTE_FOUR);
      send_byte(random_printable());
      send_byte(tle_pkg::BYTE_NEWLINE);
   endtask

   // Random lines of edits and cursor keys, with broken sequences and noise mixed in
   task automatic test_random_lines(input int item_target);
      int         sent_at_start;
      int         pick;
      logic [7:0] noise;
      sent_at_start = bytes_sent;
      while (bytes_sent - sent_at_start < item_target) begin
         repeat ($urandom_range(0, 8)) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               send_byte(random_printable());
            end else if (pick < 55) begin
               send_byte(tle_pkg::BYTE_DELETE);
            end else if (pick < 63) begin
               send_csi(tle_pkg::BYTE_LEFT);
            end else if (pick < 71) begin
               send_csi(tle_pkg::BYTE_RIGHT);
            end else if (pick < 76) begin
               send_csi_tilde(tle_pkg::BYTE_ONE);
            end else if (pick < 81) begin
               send_csi_tilde(tle_pkg::BYTE_FOUR);
            end else if (pick < 88) begin
               case ($urandom_range(2))
                  0: send_byte(tle_pkg::BYTE_ESC);
                  1: send_csi(tle_pkg::BYTE_ONE);
                  default: send_csi(tle_pkg::BYTE_FOUR);
               endcase
               send_byte(8'($urandom_range(0, 255)));
            end else begin
               if ($urandom_range(1)) begin
                  noise = 8'($urandom_range(128, 255));
               end else begin
                  do noise = 8'($urandom_range(0, 31));
                  while (noise == tle_pkg::BYTE_NEWLINE || noise == tle_pkg::BYTE_ESC);
               end
               send_byte(noise);
            end
         end
         send_byte(tle_pkg::BYTE_NEWLINE);
      end
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 0;
      stall_pct     = 0;
      test_edit_keys();
      test_escape_breaks();

      send_idle_pct = 37;
      stall_pct     = 37;
      test_full_line();

      send_idle_pct = 0;
      stall_pct     = 0;
      test_random_lines(10);
      send_idle_pct = 47;
      test_random_lines(10);
      send_idle_pct = 0;
      stall_pct     = 47;
      test_random_lines(10);
      send_idle_pct = 37;
      stall_pct     = 37;
      test_random_lines(10);

      // Drain outstanding line beats, then watch for strays
      req_if.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Fed %0d bytes of edits, cursor keys and escapes;", bytes_sent);
      $display("checked %0d characters in %0d lines.", chars_checked, lines_checked);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
